@@ hw/rtl/dmm_pkg.sv @@
// Shared widths, request and register codes, and pipeline tag type of the matrix multiplier.
`default_nettype none
package dmm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;

  localparam int REQ_W    = 2;
  localparam int COORD_W  = 3;
  localparam int VALUE_W  = 16;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int RESULT_W = 35;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIMENSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_OF_B       = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // One product term on its way through the read / multiply / accumulate stages.
  typedef struct packed {
    logic               valid;
    logic               first;   // first term of a dot product
    logic               last_k;  // final term of a dot product
    logic               last;    // dot product is the final element of C
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

endpackage
`default_nettype wire

@@ hw/rtl/dmm_if.sv @@
// Request and result channel interfaces of the matrix multiplier.
`default_nettype none
interface dmm_req_if;
  logic                                valid;
  logic                                ready;
  logic [dmm_pkg::REQ_W-1:0]           req_type;
  logic [dmm_pkg::COORD_W-1:0]         row_index;
  logic [dmm_pkg::COORD_W-1:0]         col_index;
  logic signed [dmm_pkg::VALUE_W-1:0]  element_value;

  modport source (output valid, req_type, row_index, col_index, element_value, input ready);
  modport sink (input valid, req_type, row_index, col_index, element_value, output ready);
endinterface

interface dmm_res_if;
  logic                                valid;
  logic                                ready;
  logic [dmm_pkg::COORD_W-1:0]         result_row;
  logic [dmm_pkg::COORD_W-1:0]         result_col;
  logic signed [dmm_pkg::RESULT_W-1:0] result_value;
  logic                                last;

  modport source (output valid, result_row, result_col, result_value, last, input ready);
  modport sink (input valid, result_row, result_col, result_value, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dmm_store.sv @@
// Element memories of A and B: one write port shared by loads, one registered read port each.
`default_nettype none
module dmm_store #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                wr_a,
  input  wire logic                                wr_b,
  input  wire logic [ADDR_W-1:0]                   wr_addr,
  input  wire logic [dmm_pkg::VALUE_W-1:0]         wr_data,
  input  wire logic                                rd_en,
  input  wire logic [ADDR_W-1:0]                   rd_addr_a,
  input  wire logic [ADDR_W-1:0]                   rd_addr_b,
  output logic signed [dmm_pkg::VALUE_W-1:0]       rd_a,
  output logic signed [dmm_pkg::VALUE_W-1:0]       rd_b
);
  import dmm_pkg::*;

  logic [VALUE_W-1:0] a_mem [DEPTH];
  logic [VALUE_W-1:0] b_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= a_mem[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_b <= b_mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dmm_seq.sv @@
// Sequencer: walks row, column and inner index of C and issues one term per advancing cycle.
`default_nettype none
module dmm_seq #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        done,
  input  wire logic                        adv,
  input  wire logic [dmm_pkg::CFG_W-1:0]   rows_of_a,
  input  wire logic [dmm_pkg::CFG_W-1:0]   inner_dimension,
  input  wire logic [dmm_pkg::CFG_W-1:0]   cols_of_b,
  output logic                             busy,
  output dmm_pkg::tag_t                    issue,
  output logic [ADDR_W-1:0]                rd_addr_a,
  output logic [ADDR_W-1:0]                rd_addr_b
);
  import dmm_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_DIM);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] r, c, k;
  logic [IDX_W-1:0] r_last, c_last, k_last;
  logic             final_term;

  // Zero counts as one, anything above the array size as the array size.
  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] dim);
    if (dim == '0) begin
      return '0;
    end
    if (dim > CFG_W'(MAX_DIM)) begin
      return IDX_W'(MAX_DIM - 1);
    end
    return IDX_W'(dim - 1'b1);
  endfunction

  assign final_term = (r == r_last) && (c == c_last) && (k == k_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (adv && final_term) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      r      <= '0;
      c      <= '0;
      k      <= '0;
      r_last <= last_index(rows_of_a);
      c_last <= last_index(cols_of_b);
      k_last <= last_index(inner_dimension);
    end else if (state == S_RUN && adv) begin
      if (k != k_last) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
        if (c != c_last) begin
          c <= c + 1'b1;
        end else begin
          c <= '0;
          r <= r + 1'b1;
        end
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    issue.valid  = (state == S_RUN);
    issue.first  = (k == '0);
    issue.last_k = (k == k_last);
    issue.last   = (r == r_last) && (c == c_last);
    issue.row    = COORD_W'(r);
    issue.col    = COORD_W'(c);
  end

  assign rd_addr_a = ADDR_W'(r) * ROW_STRIDE + ADDR_W'(k);
  assign rd_addr_b = ADDR_W'(k) * ROW_STRIDE + ADDR_W'(c);

endmodule
`default_nettype wire

@@ hw/rtl/dmm_mac.sv @@
// Multiply-accumulate: registered product, then a running sum that doubles as the result register.
`default_nettype none
module dmm_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 adv,
  input  wire dmm_pkg::tag_t                        issue,
  input  wire logic signed [dmm_pkg::VALUE_W-1:0]   rd_a,
  input  wire logic signed [dmm_pkg::VALUE_W-1:0]   rd_b,
  output logic                                      res_valid,
  output dmm_pkg::tag_t                             res_tag,
  output logic signed [dmm_pkg::RESULT_W-1:0]       res_value
);
  import dmm_pkg::*;

  tag_t                       tag1, tag2;
  logic signed [PROD_W-1:0]   prod;
  logic signed [RESULT_W-1:0] acc_base;

  // Restart the sum on the first term of each dot product.
  assign acc_base = tag2.first ? '0 : res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1      <= '0;
      tag2      <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      tag1      <= issue;
      tag2      <= tag1;
      res_valid <= tag2.valid && tag2.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= rd_a * rd_b;
      if (tag2.valid) begin
        res_value <= acc_base + RESULT_W'(prod);
        res_tag   <= tag2;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dense_matrix_multiply_unit.sv @@
// Top level of the dense matrix multiplier C = A x B on signed Q8.8 elements.
// Sequence: a load is written when accepted; a compute request's first C element follows its
//   store reads, product register and accumulation of K terms, K = inner dimension.
// Throughput: loads one per cycle while idle; a compute request holds the request channel
//   until its final element is taken; one term per cycle, unless a result stalls, on one multiplier.
// Reset: synchronous, active high; dimensions return to 8, element memories keep their contents.
`default_nettype none
module dense_matrix_multiply_unit #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [dmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dmm_pkg::CFG_W-1:0]       cfg_data,
  dmm_req_if.sink                              req,
  dmm_res_if.source                            res
);
  import dmm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0]  ROW_STRIDE = ADDR_W'(MAX_DIM);
  localparam logic [COORD_W:0]   COORD_LIMIT = (COORD_W + 1)'(MAX_DIM);

  // Dimension registers, stored raw and clamped when a compute starts.
  logic [CFG_W-1:0] rows_of_a, inner_dimension, cols_of_b;

  logic              req_fire, res_fire;
  logic              load_in_range;
  logic              wr_a, wr_b, start, done, busy, adv;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic signed [VALUE_W-1:0] rd_a, rd_b;
  tag_t              issue, res_tag;
  logic              res_valid;
  logic signed [RESULT_W-1:0] res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a       <= DIM_RESET;
      inner_dimension <= DIM_RESET;
      cols_of_b       <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROWS_OF_A:       rows_of_a       <= cfg_data;
        CFG_INNER_DIMENSION: inner_dimension <= cfg_data;
        CFG_COLS_OF_B:       cols_of_b       <= cfg_data;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Interlock: accept no request while a compute is issuing or draining, so a load
  // never overlaps reads of the same entry.
  assign req.ready = !busy;
  assign req_fire  = req.valid && req.ready;

  // Drop loads that fall outside the element array; loads beyond the configured size still land.
  assign load_in_range = ({1'b0, req.row_index} < COORD_LIMIT) &&
                         ({1'b0, req.col_index} < COORD_LIMIT);
  assign wr_a    = req_fire && (req.req_type == REQ_LOAD_A) && load_in_range;
  assign wr_b    = req_fire && (req.req_type == REQ_LOAD_B) && load_in_range;
  assign wr_addr = ADDR_W'(req.row_index) * ROW_STRIDE + ADDR_W'(req.col_index);
  assign start   = req_fire && (req.req_type == REQ_COMPUTE);

  // Advance the whole read / multiply / accumulate pipe unless a result waits unaccepted.
  assign adv      = !res_valid || res.ready;
  assign res_fire = res.valid && res.ready;
  assign done     = res_fire && res.last;

  dmm_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk       (clk),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .wr_addr   (wr_addr),
    .wr_data   (req.element_value),
    .rd_en     (adv),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  dmm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .done            (done),
    .adv             (adv),
    .rows_of_a       (rows_of_a),
    .inner_dimension (inner_dimension),
    .cols_of_b       (cols_of_b),
    .busy            (busy),
    .issue           (issue),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b)
  );

  dmm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .issue     (issue),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .res_valid (res_valid),
    .res_tag   (res_tag),
    .res_value (res_value)
  );

  // The accumulator register is the result register.
  assign res.valid        = res_valid;
  assign res.result_row   = res_tag.row;
  assign res.result_col   = res_tag.col;
  assign res.result_value = res_value;
  assign res.last         = res_tag.last;

  // A result only ever belongs to a compute in progress.
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !res.valid)
    else $error("result shown while no compute is in progress");

  // A compute request takes the block busy on the next cycle.
  a_compute_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_COMPUTE) |=> busy)
    else $error("compute request accepted without starting the sequencer");

  // Delivering the final element of C frees the request channel.
  a_last_frees_block: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.last) |=> !busy)
    else $error("block still busy after the final element was taken");

  // No further result follows the final element of C.
  a_nothing_after_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.last) |=> !res.valid)
    else $error("result shown after the final element of C");

endmodule
`default_nettype wire
